// File: rtl/remote_button_report_decoder_macros.svh
// Assertion macros for the remote button report decoder checker.
// Depends on nothing; included by the checker file only.
`ifndef REMOTE_BUTTON_REPORT_DECODER_MACROS_SVH
`define REMOTE_BUTTON_REPORT_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RBRD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbrd checker: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RBRD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbrd checker: next-cycle property failed");

`endif

// File: rtl/rbrd_pkg.sv
// Shared types, status codes and lookup tables of the remote button report decoder.
// Depends on nothing; imported by every module of the block.
package rbrd_pkg;

  localparam int FlagBits   = 24;
  localparam int FlagIdxW   = $clog2(FlagBits);
  localparam int KeyW       = 8;
  localparam int CodeW      = 10;
  localparam int ValueW     = 8;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 24;

  localparam logic [CodeW-1:0] CodeSentinel = 10'd767;
  localparam logic [KeyW-1:0]  PressOn      = 8'd1;

  typedef enum logic [1:0] {
    ST_EVENT = 2'd0,
    ST_NONE  = 2'd1,
    ST_UNREC = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  typedef struct packed {
    logic [FlagBits-1:0] button_flags;
    logic [KeyW-1:0]     key_byte;
    logic [KeyW-1:0]     press_byte;
    logic                short_report;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0]  key_code;
    logic [ValueW-1:0] key_value;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic [FlagBits-1:0] last_flags;
    logic [CodeW-1:0]    last_key_code;
  } state_t;

  // Flag bit number to scan code; zero means the bit has no button.
  function automatic logic [KeyW-1:0] bit_scan(input logic [FlagIdxW-1:0] idx);
    logic [KeyW-1:0] s;
    case (idx)
      5'd0:  s = 8'h43;
      5'd3:  s = 8'h0b;
      5'd8:  s = 8'h58;
      5'd9:  s = 8'h59;
      5'd10: s = 8'h5a;
      5'd11: s = 8'h5b;
      5'd12: s = 8'h5c;
      5'd13: s = 8'h5d;
      5'd14: s = 8'h5e;
      5'd15: s = 8'h5f;
      5'd16: s = 8'h50;
      5'd17: s = 8'h51;
      5'd18: s = 8'h52;
      5'd19: s = 8'h53;
      5'd20: s = 8'h54;
      5'd21: s = 8'h55;
      5'd22: s = 8'h56;
      5'd23: s = 8'h57;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Scan code to input key code; zero means unmapped.
  function automatic logic [CodeW-1:0] scan_code(input logic [KeyW-1:0] scan);
    logic [CodeW-1:0] c;
    case (scan)
      8'h16: c = 10'd161;
      8'h64: c = 10'd392;
      8'h65: c = 10'd371;
      8'h63: c = 10'd370;
      8'h0f: c = 10'd355;
      8'h28: c = 10'd359;
      8'h00: c = 10'd2;
      8'h01: c = 10'd3;
      8'h02: c = 10'd4;
      8'h03: c = 10'd5;
      8'h04: c = 10'd6;
      8'h05: c = 10'd7;
      8'h06: c = 10'd8;
      8'h07: c = 10'd9;
      8'h08: c = 10'd10;
      8'h09: c = 10'd11;
      8'h81: c = 10'd398;
      8'h82: c = 10'd399;
      8'h80: c = 10'd401;
      8'h83: c = 10'd400;
      8'h70: c = 10'd358;
      8'h1a: c = 10'd139;
      8'h40: c = 10'd438;
      8'h0e: c = 10'd1;
      8'h5c: c = 10'd357;
      8'h5d: c = 10'd158;
      8'h5f: c = 10'd375;
      8'h5e: c = 10'd256;
      8'h54: c = 10'd103;
      8'h56: c = 10'd108;
      8'h57: c = 10'd105;
      8'h55: c = 10'd106;
      8'h0b: c = 10'd28;
      8'h5a: c = 10'd310;
      8'h58: c = 10'd312;
      8'h51: c = 10'd317;
      8'h5b: c = 10'd311;
      8'h59: c = 10'd313;
      8'h52: c = 10'd318;
      8'h43: c = 10'd172;
      8'h50: c = 10'd353;
      8'h53: c = 10'd315;
      8'h33: c = 10'd168;
      8'h32: c = 10'd207;
      8'h34: c = 10'd159;
      8'h30: c = 10'd412;
      8'h38: c = 10'd128;
      8'h31: c = 10'd407;
      8'h60: c = 10'd436;
      8'h39: c = 10'd119;
      8'h61: c = 10'd437;
      8'hff: c = CodeSentinel;
      default: c = 10'd0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/rbrd_decode.sv
// Combinational decode of one report against the stored flags and last key.
// Depends on rbrd_pkg for the item, result and state types and the tables.
module rbrd_decode import rbrd_pkg::*; (
  input  item_t   item,
  input  state_t  state,
  output result_t result,
  output state_t  state_next
);

  logic [FlagBits-1:0] diff;
  logic [FlagIdxW-1:0] low_idx;
  logic [KeyW-1:0]     flag_scan;
  logic [CodeW-1:0]    key_path_code;

  assign diff = item.button_flags ^ state.last_flags;

  // Lowest changed flag bit: scanning downward lets the lowest set bit win.
  always_comb begin
    low_idx = '0;
    for (int i = FlagBits - 1; i >= 0; i--) begin
      if (diff[i]) begin
        low_idx = FlagIdxW'(i);
      end
    end
  end

  assign flag_scan     = bit_scan(low_idx);
  assign key_path_code = (item.press_byte == PressOn) ? scan_code(item.key_byte)
                                                      : state.last_key_code;

  always_comb begin
    result     = '{key_code: '0, key_value: '0, status: ST_EVENT};
    state_next = state;
    if (item.short_report) begin
      result.status = ST_SHORT;
    end else if (diff != '0) begin
      if (flag_scan == '0) begin
        result.status = ST_UNREC;
      end else begin
        result.key_code  = scan_code(flag_scan);
        result.key_value = ValueW'(item.button_flags[low_idx]);
        state_next.last_flags = item.button_flags;
      end
    end else if (key_path_code == '0) begin
      result.status = ST_UNREC;
    end else if (key_path_code == CodeSentinel) begin
      result.status = ST_NONE;
    end else begin
      result.key_code  = key_path_code;
      result.key_value = item.press_byte;
      state_next.last_key_code = key_path_code;
    end
  end

endmodule

// File: rtl/remote_button_report_decoder.sv
// Top level of the remote button report decoder: input register, decode, result register.
// Depends on rbrd_pkg and rbrd_decode.
//
//  channel  dir  tdata (low bit up)                        tuser
//  s_*      in   button_flags 24, key_byte 8, press_byte 8 short_report
//  m_*      out  key_code 10, key_value 8, zero pad 6      status 2
//
// One report per cycle is sustained while m_tready is high; a report's result shows
// on m_* once the report has passed the input register and then the result
// register, with the flag search and table lookups between.
// rst is synchronous and clears both valid flags and the stored flags and key.
// A stalled result holds in place while an empty input register still takes a
// report; the stored state advances only when a report moves into the result.
module remote_button_report_decoder import rbrd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // button_flags, key_byte, press_byte
  input  logic                s_tuser,   // short_report
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // key_code, key_value, zero pad
  output logic [1:0]          m_tuser    // status
);

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  state_t  state;
  state_t  state_next;
  result_t dec_res;
  logic    advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  rbrd_decode u_decode (
    .item       (in_item),
    .state      (state),
    .result     (dec_res),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.button_flags <= s_tdata[23:0];
      in_item.key_byte     <= s_tdata[31:24];
      in_item.press_byte   <= s_tdata[39:32];
      in_item.short_report <= s_tuser;
    end
    if (advance) begin
      out_res <= dec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_res.key_value, out_res.key_code};
  assign m_tuser  = out_res.status;

endmodule

// File: rtl/rbrd_checker.sv
// Port-level checker for the remote button report decoder, bound to the top level.
// Depends on rbrd_pkg and remote_button_report_decoder_macros.svh.
`include "remote_button_report_decoder_macros.svh"

module rbrd_checker import rbrd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic [1:0]          m_tuser
);

  logic is_event;
  assign is_event = (m_tuser == ST_EVENT);

  // Only an event carries a code and a value.
  `RBRD_ASSERT_IMP(a_no_event_zero, clk, rst, m_tvalid && !is_event, m_tdata == '0)

  // An event never carries the empty code or the sentinel code.
  `RBRD_ASSERT_IMP(a_event_code, clk, rst, m_tvalid && is_event, (m_tdata[9:0] != '0) && (m_tdata[9:0] != CodeSentinel))

  // The pad bits above the value are always zero.
  `RBRD_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[23:18] == '0)

  // With the output side ready, the input side is never blocked.
  `RBRD_ASSERT_IMP(a_ready_through, clk, rst, m_tready, s_tready)

  // A stalled result stays put.
  `RBRD_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind remote_button_report_decoder rbrd_checker u_rbrd_checker (.*);

// File: tb/remote_button_report_decoder_test.sv
// Self-checking testbench for remote_button_report_decoder: directed and random reports
// with random gaps on both stream sides, checked against a behavioral decoder model.
// Depends on rbrd_pkg and the decoder RTL.
module remote_button_report_decoder_test import rbrd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ResetCycles = 11;
  localparam int SettleCycles = 8;
  localparam int CycleLimit = 100000;
  localparam int RandomReports = 400;

  // Button bit number to scan code; a zero entry is a bit with no button.
  localparam logic [KeyW-1:0] FlagBitScan [0:FlagBits-1] = '{
    8'h43, 8'h00, 8'h00, 8'h0b, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h58, 8'h59, 8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f,
    8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57
  };

  // Every mapped scan code and its key code, in matching order.
  localparam logic [KeyW-1:0] ScanList [0:51] = '{
    8'h16, 8'h64, 8'h65, 8'h63, 8'h0f, 8'h28, 8'h00, 8'h01, 8'h02, 8'h03,
    8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h81, 8'h82, 8'h80, 8'h83,
    8'h70, 8'h1a, 8'h40, 8'h0e, 8'h5c, 8'h5d, 8'h5f, 8'h5e, 8'h54, 8'h56,
    8'h57, 8'h55, 8'h0b, 8'h5a, 8'h58, 8'h51, 8'h5b, 8'h59, 8'h52, 8'h43,
    8'h50, 8'h53, 8'h33, 8'h32, 8'h34, 8'h30, 8'h38, 8'h31, 8'h60, 8'h39,
    8'h61, 8'hff
  };
  localparam logic [CodeW-1:0] KeyCodeList [0:51] = '{
    10'd161, 10'd392, 10'd371, 10'd370, 10'd355, 10'd359, 10'd2, 10'd3,
    10'd4, 10'd5, 10'd6, 10'd7, 10'd8, 10'd9, 10'd10, 10'd11,
    10'd398, 10'd399, 10'd401, 10'd400, 10'd358, 10'd139, 10'd438, 10'd1,
    10'd357, 10'd158, 10'd375, 10'd256, 10'd103, 10'd108, 10'd105, 10'd106,
    10'd28, 10'd310, 10'd312, 10'd317, 10'd311, 10'd313, 10'd318, 10'd172,
    10'd353, 10'd315, 10'd168, 10'd207, 10'd159, 10'd412, 10'd128, 10'd407,
    10'd436, 10'd119, 10'd437, 10'd767
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;   // button_flags, key_byte, press_byte
  logic                s_tuser = 1'b0; // short_report
  logic                m_tvalid;
  logic                m_tready = 1'b1;
  logic [OutDataW-1:0] m_tdata;        // key_code, key_value, zero pad
  logic [1:0]          m_tuser;        // status

  // Decoder state as the model sees it, advanced at each input transfer.
  logic [FlagBits-1:0] model_flags = '0;
  logic [CodeW-1:0]    model_key = '0;

  result_t expected_results[$];
  bit      gaps_on = 1'b1;
  int      cycle_count = 0;
  int      error_count = 0;
  int      reports_sent = 0;
  int      results_checked = 0;
  int      status_seen [4] = '{0, 0, 0, 0};

  remote_button_report_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [CodeW-1:0] keycode_of(input logic [KeyW-1:0] scan);
    logic [CodeW-1:0] code;
    code = '0;
    foreach (ScanList[i]) if (ScanList[i] == scan) code = KeyCodeList[i];
    return code;
  endfunction

  // Decodes one report and advances the model state the way the block does.
  function automatic result_t predict_report(input item_t rep);
    result_t             res;
    logic [FlagBits-1:0] diff;
    logic [CodeW-1:0]    code;
    int                  lowest;
    res.key_code = '0;
    res.key_value = '0;
    res.status = ST_UNREC;
    if (rep.short_report) begin
      res.status = ST_SHORT;
      return res;
    end
    diff = rep.button_flags ^ model_flags;
    if (diff != '0) begin
      lowest = 0;
      for (int i = FlagBits - 1; i >= 0; i--) if (diff[i]) lowest = i;
      if (FlagBitScan[lowest] == '0) return res;
      model_flags = rep.button_flags;
      res.key_code = keycode_of(FlagBitScan[lowest]);
      res.key_value = ValueW'(rep.button_flags[lowest]);
      res.status = ST_EVENT;
      return res;
    end
    code = (rep.press_byte == PressOn) ? keycode_of(rep.key_byte) : model_key;
    if (code == '0) return res;
    if (code == CodeSentinel) begin
      res.status = ST_NONE;
      return res;
    end
    model_key = code;
    model_flags = rep.button_flags;
    res.key_code = code;
    res.key_value = rep.press_byte;
    res.status = ST_EVENT;
    return res;
  endfunction

  function automatic item_t make_report(input logic [FlagBits-1:0] flags,
                                        input logic [KeyW-1:0] key,
                                        input logic [KeyW-1:0] press,
                                        input logic short_rep);
    item_t rep;
    rep.button_flags = flags;
    rep.key_byte = key;
    rep.press_byte = press;
    rep.short_report = short_rep;
    return rep;
  endfunction

  // Mostly button toggles and key presses that follow the current state,
  // with short reports and fully random reports mixed in.
  function automatic item_t random_report();
    item_t rep;
    int    kind;
    int    b;
    kind = $urandom_range(99);
    rep = make_report(FlagBits'($urandom), KeyW'($urandom), KeyW'($urandom), 1'b0);
    if (kind < 8) begin
      rep.short_report = 1'b1;
    end else if (kind < 38) begin
      b = $urandom_range(FlagBits - 1);
      rep.button_flags = model_flags ^ (FlagBits'(1) << b);
      if ($urandom_range(3) == 0)
        rep.button_flags ^= FlagBits'($urandom) & ~((FlagBits'(2) << b) - 1'b1);
    end else if (kind < 83) begin
      rep.button_flags = model_flags;
      if ($urandom_range(9) < 7) rep.press_byte = PressOn;
      if ($urandom_range(9) < 8) rep.key_byte = ScanList[$urandom_range(51)];
    end
    return rep;
  endfunction

  task automatic send_report(input item_t rep);
    while (gaps_on && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rep.press_byte, rep.key_byte, rep.button_flags};
    s_tuser <= rep.short_report;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_report(rep));
    reports_sent++;
  endtask

  // Holds the input side until every pending result has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Key reuse while no key is stored yet decodes as unrecognized.
  task automatic test_reuse_before_key();
    send_report(make_report(24'h000000, 8'h0b, 8'h00, 1'b0));
    send_report(make_report(24'h000000, 8'hff, 8'hff, 1'b0));
  endtask

  task automatic test_short_reports();
    send_report(make_report(24'hffffff, 8'hff, 8'hff, 1'b1));
    send_report(make_report(24'h000000, 8'h00, 8'h00, 1'b1));
    send_report(make_report(24'h000001, 8'h0b, 8'h01, 1'b1));
  endtask

  // Presses and releases on mapped bits, unmapped bits, and full-word flips.
  task automatic test_flag_events();
    send_report(make_report(24'h000001, 8'h00, 8'h00, 1'b0));
    send_report(make_report(24'h000000, 8'h00, 8'h00, 1'b0));
    send_report(make_report(24'h000002, 8'h00, 8'h00, 1'b0));
    send_report(make_report(24'h000008, 8'h00, 8'h00, 1'b0));
    send_report(make_report(24'hffffff, 8'hff, 8'hff, 1'b0));
    send_report(make_report(24'h7fffff, 8'h00, 8'h01, 1'b0));
    send_report(make_report(24'hffffff, 8'h00, 8'h00, 1'b0));
    send_report(make_report(24'h000000, 8'h00, 8'h00, 1'b0));
    send_report(make_report(24'h000010, 8'h00, 8'h00, 1'b0));
  endtask

  // Unchanged flags: key lookup, key reuse, unmapped key and the no-event key.
  task automatic test_key_path();
    send_report(make_report(24'h000000, 8'h0b, 8'h01, 1'b0));
    send_report(make_report(24'h000000, 8'h00, 8'h00, 1'b0));
    send_report(make_report(24'h000000, 8'h00, 8'hff, 1'b0));
    send_report(make_report(24'h000000, 8'h10, 8'h01, 1'b0));
    send_report(make_report(24'h000000, 8'hff, 8'h01, 1'b0));
    send_report(make_report(24'h000000, 8'h00, 8'h01, 1'b0));
    send_report(make_report(24'h000000, 8'hff, 8'h02, 1'b0));
  endtask

  task automatic test_random_reports(input int count);
    for (int i = 0; i < count; i++) begin
      gaps_on = !(i >= 150 && i < 250);
      if (i == 300) wait_drained();
      send_report(random_report());
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) m_tready <= !(gaps_on && $urandom_range(99) < 6);

  always @(posedge clk) begin : check_result
    result_t          want;
    logic [CodeW-1:0] got_code;
    logic [ValueW-1:0] got_value;
    if (!rst && m_tvalid && m_tready) begin
      got_code = m_tdata[CodeW-1:0];
      got_value = m_tdata[CodeW+ValueW-1:CodeW];
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: code %0d value %0d status %0d",
                 $time, got_code, got_value, m_tuser);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (got_code !== want.key_code) begin
          $display("%0t: key_code expected %0d got %0d", $time, want.key_code, got_code);
          error_count++;
        end
        if (got_value !== want.key_value) begin
          $display("%0t: key_value expected %0d got %0d", $time, want.key_value, got_value);
          error_count++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("remote_button_report_decoder_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    test_reuse_before_key();
    test_short_reports();
    test_flag_events();
    test_key_path();
    wait_drained();
    test_random_reports(RandomReports);
    wait_drained();
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    $display("Sent %0d reports, checked %0d results in %0d cycles.", reports_sent,
             results_checked, cycle_count);
    $display("Outcomes: %0d events, %0d no-event keys, %0d unrecognized, %0d short.",
             status_seen[ST_EVENT], status_seen[ST_NONE], status_seen[ST_UNREC],
             status_seen[ST_SHORT]);
    if (error_count == 0) begin
      $display("remote_button_report_decoder_test: clean");
    end else begin
      $display("remote_button_report_decoder_test: errors");
    end
    $finish;
  end

endmodule
